FILE: design/lpvr_pkg.sv
package lpvr_pkg;

  // Default sizes
  localparam int LAYERS_DEF       = 8;
  localparam int FIXTURES_DEF     = 256;
  localparam int PROPERTIES_DEF   = 16;
  localparam int SAFETY_LAYER_DEF = 7;

  localparam int LEVEL_W = 17;
  localparam int MODE_W  = 2;
  localparam int SRC_W   = 3;
  localparam int PROP_W  = 5;
  localparam int REQ_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'd65536;

  // Entry modes
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FORCE   = 2'd2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CLR_LAYER = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLR_ALL   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESOLVE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_BELOW     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SAFE      = 3'd5;

  // Property codes with safety rules
  localparam logic [PROP_W-1:0] PROP_INTENSITY = 5'd0;
  localparam logic [PROP_W-1:0] PROP_STROBE    = 5'd1;
  localparam logic [PROP_W-1:0] PROP_FOG       = 5'd2;
  localparam logic [PROP_W-1:0] PROP_HAZE      = 5'd3;
  localparam logic [PROP_W-1:0] PROP_LASER     = 5'd4;
  localparam logic [PROP_W-1:0] PROP_SPARK     = 5'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOG_EN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAZE_EN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LASER_EN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARK_EN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STROBE_EN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STROBE_CAP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_CAP = 3'd6;

  typedef struct packed {
    logic               fog_en;
    logic               haze_en;
    logic               laser_en;
    logic               spark_en;
    logic               strobe_en;
    logic [LEVEL_W-1:0] strobe_cap;
    logic [LEVEL_W-1:0] intensity_cap;
  } lpvr_cfg_t;

  // Scan result handed from the sequencer to the safety stage
  typedef struct packed {
    logic               owned;
    logic [LEVEL_W-1:0] level;
    logic [MODE_W-1:0]  mode;
    logic [SRC_W-1:0]   src;
    logic               safe;
    logic [PROP_W-1:0]  prop;
  } lpvr_res_t;

endpackage

FILE: design/lpvr_if.sv
interface lpvr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  layer_sel;
  logic [15:0] fixture_sel;
  logic [4:0]  property_sel;
  logic [1:0]  write_mode;
  logic signed [17:0] write_level;

  modport source (output valid, req_type, layer_sel, fixture_sel, property_sel,
                  write_mode, write_level, input ready);
  modport sink (input valid, req_type, layer_sel, fixture_sel, property_sel,
                write_mode, write_level, output ready);
endinterface

interface lpvr_out_if;
  logic        valid;
  logic        ready;
  logic        owned;
  logic [16:0] level;
  logic [1:0]  level_mode;
  logic [2:0]  source_layer;

  modport source (output valid, owned, level, level_mode, source_layer, input ready);
  modport sink (input valid, owned, level, level_mode, source_layer, output ready);
endinterface

FILE: design/layered_priority_value_resolver.sv
// Flow: a write is stored as it is accepted; resolve, resolve below and safe resolve are
//   accepted, then scan the layers top-down (one table read per layer below top, top =
//   LAYERS or the given layer), hand off, and the result beat sits in the output register.
// One item at a time; a resolve holds the block until its result is handed off, as the scan
//   reads the layers one by one through the single read port of the layer table. Clear layer
//   sweeps 2**(FW+PW) entries (4096 at default sizes), clear all sweeps all 2**AW (32768).
// Reset: synchronous active-low rst_n; after reset a clearing pass writes release to every
//   table entry (2**AW entries, 32768 at default sizes) while in_bus.ready stays low.
//   Configuration registers reset to all effects disabled and both caps at 1.0.
module layered_priority_value_resolver import lpvr_pkg::*; #(
  parameter int LAYERS       = LAYERS_DEF,
  parameter int FIXTURES     = FIXTURES_DEF,
  parameter int PROPERTIES   = PROPERTIES_DEF,
  parameter int SAFETY_LAYER = SAFETY_LAYER_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lpvr_in_if.sink              in_bus,
  lpvr_out_if.source           out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_wdata
);

  // Table address is {layer, fixture, property}, each field rounded up to a power of two
  localparam int LW = $clog2(LAYERS);
  localparam int FW = (FIXTURES > 1) ? $clog2(FIXTURES) : 1;
  localparam int PW = $clog2(PROPERTIES);
  localparam int AW = LW + FW + PW;
  localparam int EW = MODE_W + LEVEL_W;

  lpvr_cfg_t cfg_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic      done;
  logic      free;
  lpvr_res_t res;

  // Configuration registers: accept a write whenever cfg_we is high, drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fog_en        <= 1'b0;
      cfg_r.haze_en       <= 1'b0;
      cfg_r.laser_en      <= 1'b0;
      cfg_r.spark_en      <= 1'b0;
      cfg_r.strobe_en     <= 1'b0;
      cfg_r.strobe_cap    <= ONE_Q16;
      cfg_r.intensity_cap <= ONE_Q16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOG_EN:        cfg_r.fog_en        <= cfg_wdata[0];
        CFG_HAZE_EN:       cfg_r.haze_en       <= cfg_wdata[0];
        CFG_LASER_EN:      cfg_r.laser_en      <= cfg_wdata[0];
        CFG_SPARK_EN:      cfg_r.spark_en      <= cfg_wdata[0];
        CFG_STROBE_EN:     cfg_r.strobe_en     <= cfg_wdata[0];
        CFG_STROBE_CAP:    cfg_r.strobe_cap    <= cfg_wdata;
        CFG_INTENSITY_CAP: cfg_r.intensity_cap <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Layer table: one entry of mode and level per layer, fixture and property
  lpvr_ram #(
    .WIDTH (EW),
    .DEPTH (2**AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: writes, clearing sweeps and the top-down layer scan
  lpvr_ctrl #(
    .LAYERS     (LAYERS),
    .FIXTURES   (FIXTURES),
    .PROPERTIES (PROPERTIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done_o    (done),
    .res_o     (res),
    .free_i    (free)
  );

  // Safety overrides and caps, then the output register
  lpvr_safety #(
    .SAFETY_LAYER (SAFETY_LAYER)
  ) u_safety (
    .clk    (clk),
    .rst_n  (rst_n),
    .done_i (done),
    .res_i  (res),
    .cfg_i  (cfg_r),
    .free_o (free),
    .out_ch (out_bus)
  );

endmodule

FILE: design/lpvr_ram.sv
module lpvr_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lpvr_ctrl.sv
module lpvr_ctrl import lpvr_pkg::*; #(
  parameter int LAYERS     = LAYERS_DEF,
  parameter int FIXTURES   = FIXTURES_DEF,
  parameter int PROPERTIES = PROPERTIES_DEF,
  localparam int LW  = $clog2(LAYERS),
  localparam int FW  = (FIXTURES > 1) ? $clog2(FIXTURES) : 1,
  localparam int PW  = $clog2(PROPERTIES),
  localparam int AW  = LW + FW + PW,
  localparam int EW  = MODE_W + LEVEL_W
) (
  input  logic           clk,
  input  logic           rst_n,
  lpvr_in_if.sink        in_ch,
  // table port
  output logic           ram_we,
  output logic [AW-1:0]  ram_waddr,
  output logic [EW-1:0]  ram_wdata,
  output logic [AW-1:0]  ram_raddr,
  input  logic [EW-1:0]  ram_rdata,
  // result handoff
  output logic           done_o,
  output lpvr_res_t      res_o,
  input  logic           free_i
);

  localparam int FPW = FW + PW;
  localparam int CW  = $clog2(LAYERS + 1);
  localparam int PXW = 7;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic          clr_all_r, clr_all_nxt;
  logic [LW-1:0] clr_layer_r, clr_layer_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [LW-1:0] pend_layer_r, pend_layer_nxt;
  logic [FW-1:0] fix_r, fix_nxt;
  logic [PW-1:0] prop_r, prop_nxt;
  lpvr_res_t     res_r, res_nxt;

  logic               accept;
  logic               layer_ok, fix_ok, prop_ok, wr_ok;
  logic [PXW-1:0]     prop_ext;
  logic [LEVEL_W-1:0] set_level;
  logic [LEVEL_W-1:0] wr_level;
  logic               sweep_end;
  logic [AW-1:0]      sweep_addr;
  logic [CW-1:0]      scan_top;
  logic [MODE_W-1:0]  rd_mode;
  logic [LEVEL_W-1:0] rd_level;
  logic               hit;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign prop_ext = PXW'(in_ch.property_sel);
  assign layer_ok = (5'(in_ch.layer_sel) < 5'(LAYERS));
  assign fix_ok   = (17'(in_ch.fixture_sel) < 17'(FIXTURES));
  assign prop_ok  = (prop_ext < PXW'(PROPERTIES));
  assign wr_ok    = layer_ok && fix_ok && prop_ok && (in_ch.write_mode != 2'd3);

  // Clamp a set-mode level to 0..1.0
  always_comb begin
    priority if (in_ch.write_level[17]) begin
      set_level = '0;
    end else if (in_ch.write_level[16:0] > ONE_Q16) begin
      set_level = ONE_Q16;
    end else begin
      set_level = in_ch.write_level[16:0];
    end
  end
  assign wr_level = (in_ch.write_mode == MODE_SET) ? set_level : '0;

  assign sweep_addr = clr_all_r ? sweep_r : {clr_layer_r, sweep_r[FPW-1:0]};
  assign sweep_end  = clr_all_r ? (sweep_r == '1) : (sweep_r[FPW-1:0] == '1);

  assign scan_top = ((in_ch.req_type == REQ_BELOW) && layer_ok) ?
                    CW'(in_ch.layer_sel) : CW'(LAYERS);

  assign ram_raddr = {LW'(cnt_r - 1'b1), fix_r, prop_r};
  assign rd_mode   = ram_rdata[EW-1 -: MODE_W];
  assign rd_level  = ram_rdata[LEVEL_W-1:0];
  assign hit       = pend_r && (rd_mode != MODE_RELEASE);

  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    clr_all_nxt    = clr_all_r;
    clr_layer_nxt  = clr_layer_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_layer_nxt = pend_layer_r;
    fix_nxt        = fix_r;
    prop_nxt       = prop_r;
    res_nxt        = res_r;
    ram_we         = 1'b0;
    ram_waddr      = {in_ch.layer_sel[LW-1:0], in_ch.fixture_sel[FW-1:0], prop_ext[PW-1:0]};
    ram_wdata      = {in_ch.write_mode, wr_level};

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_end) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_ch.req_type)
            REQ_WRITE: begin
              ram_we = wr_ok;
            end
            REQ_CLR_LAYER: begin
              if (layer_ok) begin
                clr_all_nxt   = 1'b0;
                clr_layer_nxt = in_ch.layer_sel[LW-1:0];
                sweep_nxt     = '0;
                state_nxt     = S_CLR;
              end
            end
            REQ_CLR_ALL: begin
              clr_all_nxt = 1'b1;
              sweep_nxt   = '0;
              state_nxt   = S_CLR;
            end
            REQ_RESOLVE, REQ_BELOW, REQ_SAFE: begin
              // out-of-range fixture or property sees an all-release column
              cnt_nxt      = (fix_ok && prop_ok) ? scan_top : '0;
              pend_nxt     = 1'b0;
              fix_nxt      = in_ch.fixture_sel[FW-1:0];
              prop_nxt     = prop_ext[PW-1:0];
              res_nxt      = '0;
              res_nxt.safe = (in_ch.req_type == REQ_SAFE);
              res_nxt.prop = in_ch.property_sel;
              state_nxt    = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // one read issued per cycle, its data checked the cycle after
        priority if (hit) begin
          res_nxt.owned = 1'b1;
          res_nxt.level = (rd_mode == MODE_FORCE) ? '0 : rd_level;
          res_nxt.mode  = rd_mode;
          res_nxt.src   = SRC_W'(pend_layer_r);
          pend_nxt      = 1'b0;
          state_nxt     = S_FIN;
        end else if (cnt_r != '0) begin
          pend_nxt       = 1'b1;
          pend_layer_nxt = LW'(cnt_r - 1'b1);
          cnt_nxt        = cnt_r - 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (free_i) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      sweep_r   <= '0;
      clr_all_r <= 1'b1;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sweep_r   <= sweep_nxt;
      clr_all_r <= clr_all_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_layer_r  <= clr_layer_nxt;
    pend_layer_r <= pend_layer_nxt;
    fix_r        <= fix_nxt;
    prop_r       <= prop_nxt;
    res_r        <= res_nxt;
  end

  assign done_o = (state_r == S_FIN);
  assign res_o  = res_r;

`ifndef NO_ASSERTIONS
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !free_i) |=> (state_r == S_FIN && $stable(res_r)))
    else $error("finished result not held while safety stage is full");

  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SCAN))
    else $error("outstanding table read outside a scan");

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLR || state_r == S_IDLE))
    else $error("table written during a scan or handoff");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(LAYERS))
    else $error("layer count beyond layer total");
`endif

endmodule

FILE: design/lpvr_safety.sv
module lpvr_safety import lpvr_pkg::*; #(
  parameter int SAFETY_LAYER = SAFETY_LAYER_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       done_i,
  input  lpvr_res_t  res_i,
  input  lpvr_cfg_t  cfg_i,
  output logic       free_o,
  lpvr_out_if.source out_ch
);

  localparam logic [SRC_W-1:0] SAFE_SRC = SRC_W'(SAFETY_LAYER);

  logic               valid_r;
  logic               owned_r, owned_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [SRC_W-1:0]   src_r, src_nxt;
  logic               forced;
  logic               load;

  assign forced = (res_i.prop == PROP_FOG    && !cfg_i.fog_en)   ||
                  (res_i.prop == PROP_HAZE   && !cfg_i.haze_en)  ||
                  (res_i.prop == PROP_LASER  && !cfg_i.laser_en) ||
                  (res_i.prop == PROP_SPARK  && !cfg_i.spark_en) ||
                  (res_i.prop == PROP_STROBE && !cfg_i.strobe_en);

  always_comb begin
    owned_nxt = res_i.owned;
    level_nxt = res_i.level;
    mode_nxt  = res_i.mode;
    src_nxt   = res_i.src;
    priority if (res_i.safe && forced) begin
      owned_nxt = 1'b1;
      level_nxt = '0;
      mode_nxt  = MODE_FORCE;
      src_nxt   = SAFE_SRC;
    end else if (res_i.safe && res_i.owned && res_i.prop == PROP_STROBE &&
                 res_i.level > cfg_i.strobe_cap) begin
      level_nxt = cfg_i.strobe_cap;
      src_nxt   = SAFE_SRC;
    end else if (res_i.safe && res_i.owned && res_i.prop == PROP_INTENSITY &&
                 res_i.level > cfg_i.intensity_cap) begin
      level_nxt = cfg_i.intensity_cap;
      src_nxt   = SAFE_SRC;
    end else begin
    end
  end

  assign free_o = !valid_r || out_ch.ready;
  assign load   = done_i && free_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      owned_r <= owned_nxt;
      level_r <= level_nxt;
      mode_r  <= mode_nxt;
      src_r   <= src_nxt;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.owned        = owned_r;
  assign out_ch.level        = level_r;
  assign out_ch.level_mode   = mode_r;
  assign out_ch.source_layer = src_r;

`ifndef NO_ASSERTIONS
  a_unowned_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !owned_r) |-> (level_r == '0 && mode_r == MODE_RELEASE && src_r == '0))
    else $error("unowned result carries a level, mode or source");

  a_force_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && mode_r == MODE_FORCE) |-> (level_r == '0))
    else $error("force-zero result with nonzero level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (level_r <= ONE_Q16))
    else $error("resolved level above 1.0");
`endif

endmodule

FILE: test/layered_priority_value_resolver_tb.sv
module layered_priority_value_resolver_tb;
  import lpvr_pkg::*;

  localparam int LAYERS       = LAYERS_DEF;
  localparam int FIXTURES     = FIXTURES_DEF;
  localparam int PROPERTIES   = PROPERTIES_DEF;
  localparam int SAFETY_LAYER = SAFETY_LAYER_DEF;
  localparam int ENTRIES      = LAYERS * FIXTURES * PROPERTIES;

  // Request and mode codes the package leaves unnamed; the block must ignore them
  localparam logic [REQ_W-1:0]  REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0]  REQ_SPARE_B = 3'd7;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  // Random-phase layout
  localparam int PHASES         = 5;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int QUIET_FROM     = 30;
  localparam int SETTLE_CYCLES  = LAYERS + 8;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [3:0]         layer;
    logic [15:0]        fixture;
    logic [PROP_W-1:0]  prop;
    logic [MODE_W-1:0]  mode;
    logic [17:0]        wlevel;
  } lpvr_req_t;

  typedef struct packed {
    logic               owned;
    logic [LEVEL_W-1:0] level;
    logic [MODE_W-1:0]  mode;
    logic [SRC_W-1:0]   src;
  } lpvr_beat_t;

  // Shadow copy of the layer table and safety registers, plus the results
  // still owed by the block in acceptance order.
  class level_tracker;
    bit [MODE_W-1:0]  ent_mode  [ENTRIES];
    bit [LEVEL_W-1:0] ent_level [ENTRIES];
    bit               fog_on, haze_on, laser_on, spark_on, strobe_on;
    bit [LEVEL_W-1:0] strobe_lim, intensity_lim;
    lpvr_beat_t       pending_res [$];
    int               errors;
    int               beats_seen;

    function new();
      wipe();
      fog_on = 0; haze_on = 0; laser_on = 0; spark_on = 0; strobe_on = 0;
      strobe_lim    = ONE_Q16;
      intensity_lim = ONE_Q16;
      errors        = 0;
      beats_seen    = 0;
    endfunction

    function void wipe();
      foreach (ent_mode[i]) begin
        ent_mode[i]  = MODE_RELEASE;
        ent_level[i] = '0;
      end
    endfunction

    function int slot(int l, int f, int p);
      return (l * FIXTURES + f) * PROPERTIES + p;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
      case (idx)
        CFG_FOG_EN:        fog_on        = val[0];
        CFG_HAZE_EN:       haze_on       = val[0];
        CFG_LASER_EN:      laser_on      = val[0];
        CFG_SPARK_EN:      spark_on      = val[0];
        CFG_STROBE_EN:     strobe_on     = val[0];
        CFG_STROBE_CAP:    strobe_lim    = val;
        CFG_INTENSITY_CAP: intensity_lim = val;
        default: ;
      endcase
    endfunction

    // First non-released entry from layer top-1 down to 0
    function lpvr_beat_t top_owner(int top, int f, int p);
      lpvr_beat_t r;
      int         i;
      int         s;
      r = '0;
      if (f >= FIXTURES || p >= PROPERTIES) return r;
      for (i = top; i > 0; i--) begin
        s = slot(i - 1, f, p);
        if (ent_mode[s] == MODE_RELEASE) continue;
        r.owned = 1'b1;
        r.level = (ent_mode[s] == MODE_FORCE) ? '0 : ent_level[s];
        r.mode  = ent_mode[s];
        r.src   = SRC_W'(i - 1);
        return r;
      end
      return r;
    endfunction

    function void accept_request(lpvr_req_t rq);
      int               l, f, p, s, lv;
      logic [LEVEL_W-1:0] v;
      lpvr_beat_t       r;
      bit               forced;
      l  = int'(rq.layer);
      f  = int'(rq.fixture);
      p  = int'(rq.prop);
      lv = int'($signed(rq.wlevel));
      case (rq.req)
        REQ_WRITE: begin
          if (l < LAYERS && f < FIXTURES && p < PROPERTIES && rq.mode != MODE_SPARE) begin
            v = '0;
            if (rq.mode == MODE_SET) begin
              if (lv < 0) v = '0;
              else if (lv > int'(ONE_Q16)) v = ONE_Q16;
              else v = LEVEL_W'(lv);
            end
            s = slot(l, f, p);
            ent_mode[s]  = rq.mode;
            ent_level[s] = v;
          end
        end
        REQ_CLR_LAYER: begin
          if (l < LAYERS) begin
            for (s = slot(l, 0, 0); s < slot(l + 1, 0, 0); s++) begin
              ent_mode[s]  = MODE_RELEASE;
              ent_level[s] = '0;
            end
          end
        end
        REQ_CLR_ALL: wipe();
        REQ_RESOLVE: pending_res.push_back(top_owner(LAYERS, f, p));
        REQ_BELOW:   pending_res.push_back(top_owner((l < LAYERS) ? l : LAYERS, f, p));
        REQ_SAFE: begin
          forced = (rq.prop == PROP_FOG    && !fog_on)   ||
                   (rq.prop == PROP_HAZE   && !haze_on)  ||
                   (rq.prop == PROP_LASER  && !laser_on) ||
                   (rq.prop == PROP_SPARK  && !spark_on) ||
                   (rq.prop == PROP_STROBE && !strobe_on);
          r = top_owner(LAYERS, f, p);
          if (forced) begin
            r.owned = 1'b1;
            r.level = '0;
            r.mode  = MODE_FORCE;
            r.src   = SRC_W'(SAFETY_LAYER);
          end else begin
            if (rq.prop == PROP_STROBE && r.owned && r.level > strobe_lim) begin
              r.level = strobe_lim;
              r.src   = SRC_W'(SAFETY_LAYER);
            end
            if (rq.prop == PROP_INTENSITY && r.owned && r.level > intensity_lim) begin
              r.level = intensity_lim;
              r.src   = SRC_W'(SAFETY_LAYER);
            end
          end
          pending_res.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_beat(lpvr_beat_t got);
      lpvr_beat_t want;
      beats_seen++;
      if (pending_res.size() == 0) begin
        $error("result beat with nothing pending: owned=%0d level=%0d mode=%0d src=%0d",
               got.owned, got.level, got.mode, got.src);
        errors++;
        return;
      end
      want = pending_res.pop_front();
      if (got.owned !== want.owned) begin
        $error("owned: expected %0d, got %0d", want.owned, got.owned);
        errors++;
      end
      if (got.level !== want.level) begin
        $error("level: expected %0d, got %0d", want.level, got.level);
        errors++;
      end
      if (got.mode !== want.mode) begin
        $error("level_mode: expected %0d, got %0d", want.mode, got.mode);
        errors++;
      end
      if (got.src !== want.src) begin
        $error("source_layer: expected %0d, got %0d", want.src, got.src);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]   cfg_wdata;

  lpvr_in_if  in_bus ();
  lpvr_out_if out_bus ();

  level_tracker sb;
  bit           quiet;        // no idling on either side once set
  int           rx_hold;      // remaining stall cycles on the result side
  int           clr_layer_left;
  int           clr_all_left;
  int           req_count [8];
  lpvr_beat_t   seen;

  layered_priority_value_resolver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop; sized for the reset sweep, every clear sweep and worst-case stalls many times over
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  // Result side: stall in random bursts, change ready only on the falling edge
  always @(negedge clk) begin
    if (!quiet && rx_hold == 0 && $urandom_range(0, 99) < 12) rx_hold = $urandom_range(1, 9);
    if (rx_hold > 0) begin
      out_bus.ready = 1'b0;
      rx_hold--;
    end else begin
      out_bus.ready = 1'b1;
    end
  end

  // Sample the result channel at the rising edge; each accepted beat is checked in order
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      seen = '{out_bus.owned, out_bus.level, out_bus.level_mode, out_bus.source_layer};
      sb.check_beat(seen);
    end
  end

  // Present one request beat and hold it until the block takes it. Valid stays
  // high on return so back-to-back beats never drop it within a time step.
  task automatic send_req(lpvr_req_t rq);
    @(negedge clk);
    in_bus.valid        = 1'b1;
    in_bus.req_type     = rq.req;
    in_bus.layer_sel    = rq.layer;
    in_bus.fixture_sel  = rq.fixture;
    in_bus.property_sel = rq.prop;
    in_bus.write_mode   = rq.mode;
    in_bus.write_level  = rq.wlevel;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.accept_request(rq);
    req_count[rq.req]++;
  endtask

  task automatic send_fields(logic [REQ_W-1:0] req, logic [3:0] layer, logic [15:0] fixture,
                             logic [PROP_W-1:0] prop, logic [MODE_W-1:0] mode,
                             logic [17:0] wlevel);
    lpvr_req_t rq;
    rq = '{req, layer, fixture, prop, mode, wlevel};
    send_req(rq);
  endtask

  // Unless quiet, now and then drop valid for a random burst of cycles
  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 99) < 20) begin
      n = $urandom_range(1, 9);
      @(negedge clk);
      in_bus.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Push a resolve as a fence, then hold off until every owed result is back.
  // Since the block works on one beat at a time, it is idle once the fence returns.
  task automatic drain_block();
    send_fields(REQ_RESOLVE, 4'd0, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (sb.pending_res.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
  endtask

  // Write all seven registers; enables carry random upper bits, which must be ignored
  task automatic apply_setting(logic [4:0] en, logic [LEVEL_W-1:0] scap,
                               logic [LEVEL_W-1:0] icap);
    write_cfg(CFG_FOG_EN,    {16'($urandom), en[4]});
    write_cfg(CFG_HAZE_EN,   {16'($urandom), en[3]});
    write_cfg(CFG_LASER_EN,  {16'($urandom), en[2]});
    write_cfg(CFG_SPARK_EN,  {16'($urandom), en[1]});
    write_cfg(CFG_STROBE_EN, {16'($urandom), en[0]});
    write_cfg(CFG_STROBE_CAP, scap);
    write_cfg(CFG_INTENSITY_CAP, icap);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly a few fixtures and the named properties so writes and resolves meet;
  // the rest spreads over the full field ranges, out-of-range values included.
  function automatic lpvr_req_t rand_req();
    lpvr_req_t rq;
    int        r;
    r = $urandom_range(0, 999);
    if (r < 400) rq.req = REQ_WRITE;
    else if (r < 600) rq.req = REQ_RESOLVE;
    else if (r < 730) rq.req = REQ_BELOW;
    else if (r < 930) rq.req = REQ_SAFE;
    else if (r < 960) rq.req = ($urandom_range(0, 1) != 0) ? REQ_SPARE_A : REQ_SPARE_B;
    else if (r < 990) rq.req = (clr_layer_left > 0) ? REQ_CLR_LAYER : REQ_WRITE;
    else rq.req = (clr_all_left > 0) ? REQ_CLR_ALL : REQ_RESOLVE;
    if (rq.req == REQ_CLR_LAYER) clr_layer_left--;
    if (rq.req == REQ_CLR_ALL) clr_all_left--;

    r = $urandom_range(0, 99);
    if (r < 85) rq.layer = 4'($urandom_range(0, LAYERS - 1));
    else rq.layer = 4'($urandom_range(LAYERS, 15));

    r = $urandom_range(0, 99);
    if (r < 80) rq.fixture = 16'($urandom_range(0, 3));
    else if (r < 90) rq.fixture = 16'($urandom_range(0, FIXTURES - 1));
    else rq.fixture = 16'($urandom_range(0, 65535));

    r = $urandom_range(0, 99);
    if (r < 70) rq.prop = PROP_W'($urandom_range(0, 5));
    else if (r < 88) rq.prop = PROP_W'($urandom_range(6, PROPERTIES - 1));
    else rq.prop = PROP_W'($urandom_range(PROPERTIES, 31));

    r = $urandom_range(0, 99);
    if (r < 60) rq.mode = MODE_SET;
    else if (r < 78) rq.mode = MODE_FORCE;
    else if (r < 95) rq.mode = MODE_RELEASE;
    else rq.mode = MODE_SPARE;

    r = $urandom_range(0, 99);
    if (r < 45) rq.wlevel = 18'($urandom_range(0, 65536));
    else if (r < 70) rq.wlevel = 18'($urandom_range(0, 262143));
    else begin
      case ($urandom_range(0, 5))
        0: rq.wlevel = 18'h20000;   // most negative
        1: rq.wlevel = 18'h1FFFF;   // most positive
        2: rq.wlevel = 18'h10000;   // exactly 1.0
        3: rq.wlevel = 18'h10001;   // just above 1.0
        4: rq.wlevel = 18'h00000;
        default: rq.wlevel = 18'h3FFFF;  // -1
      endcase
    end
    return rq;
  endfunction

  initial begin
    lpvr_req_t rq;
    int        ph;
    int        k;

    // Drive every input to a known value from time zero
    in_bus.valid        = 1'b0;
    in_bus.req_type     = REQ_WRITE;
    in_bus.layer_sel    = '0;
    in_bus.fixture_sel  = '0;
    in_bus.property_sel = '0;
    in_bus.write_mode   = MODE_RELEASE;
    in_bus.write_level  = '0;
    out_bus.ready       = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_FOG_EN;
    cfg_wdata           = '0;
    quiet               = 1'b0;
    rx_hold             = 0;
    clr_layer_left      = 10;
    clr_all_left        = 2;
    foreach (req_count[i]) req_count[i] = 0;
    sb = new();

    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Hold off until the post-reset clearing sweep lets the input side open
    do @(posedge clk); while (in_bus.ready !== 1'b1);

    // Directed part, reset register values: empty table first
    send_fields(REQ_RESOLVE, 4'd0, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    // Set levels clamp at both ends
    send_fields(REQ_WRITE, 4'd0, 16'd0, PROP_INTENSITY, MODE_SET, 18'h1FFFF);
    send_fields(REQ_WRITE, 4'd3, 16'd0, PROP_INTENSITY, MODE_SET, 18'h20000);
    send_fields(REQ_RESOLVE, 4'd0, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    // Resolve below a given layer, and below "none" acting as a full resolve
    send_fields(REQ_BELOW, 4'd3, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    send_fields(REQ_BELOW, 4'd8, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    // Force zero on the top layer stores no level, then release it again
    send_fields(REQ_WRITE, 4'd7, 16'd0, PROP_INTENSITY, MODE_FORCE, 18'd1234);
    send_fields(REQ_RESOLVE, 4'd0, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    send_fields(REQ_WRITE, 4'd7, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd777);
    // Writes that must be dropped: spare mode, layer, fixture and property out of range
    send_fields(REQ_WRITE, 4'd5, 16'd0, PROP_INTENSITY, MODE_SPARE, 18'd500);
    send_fields(REQ_WRITE, 4'd15, 16'd0, PROP_INTENSITY, MODE_SET, 18'd500);
    send_fields(REQ_WRITE, 4'd1, 16'hFFFF, PROP_INTENSITY, MODE_SET, 18'd500);
    send_fields(REQ_WRITE, 4'd1, 16'd0, 5'd31, MODE_SET, 18'd500);
    send_fields(REQ_RESOLVE, 4'd0, 16'hFFFF, 5'd16, MODE_RELEASE, 18'd0);
    send_fields(REQ_RESOLVE, 4'd0, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    // Safety rule still applies to an out-of-range fixture; strobe disabled at reset
    send_fields(REQ_SAFE, 4'd0, 16'hFFFF, PROP_FOG, MODE_RELEASE, 18'd0);
    send_fields(REQ_WRITE, 4'd2, 16'd1, PROP_STROBE, MODE_SET, 18'd40000);
    send_fields(REQ_SAFE, 4'd0, 16'd1, PROP_STROBE, MODE_RELEASE, 18'd0);
    send_fields(REQ_SAFE, 4'd0, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    // Spare request codes give no result
    send_fields(REQ_SPARE_A, 4'd0, 16'd0, PROP_INTENSITY, MODE_SET, 18'd9);
    send_fields(REQ_SPARE_B, 4'd0, 16'd0, PROP_INTENSITY, MODE_SET, 18'd9);
    // Clear one layer, an out-of-range layer, then everything
    send_fields(REQ_CLR_LAYER, 4'd3, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    send_fields(REQ_RESOLVE, 4'd0, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    send_fields(REQ_CLR_LAYER, 4'd9, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    send_fields(REQ_CLR_ALL, 4'd0, 16'd0, PROP_INTENSITY, MODE_RELEASE, 18'd0);
    drain_block();

    // Random phases, each under its own register setting
    for (ph = 1; ph <= PHASES; ph++) begin
      case (ph)
        1: apply_setting(5'b11111, ONE_Q16, ONE_Q16);
        2: apply_setting(5'b11111, '0, '0);
        3: apply_setting(5'($urandom), LEVEL_W'($urandom_range(0, 65536)),
                         LEVEL_W'($urandom_range(0, 65536)));
        4: apply_setting(5'b00000, 17'h1FFFF, 17'h1FFFF);   // caps above 1.0 never bite
        default: apply_setting(5'($urandom), LEVEL_W'($urandom_range(0, 131071)),
                               LEVEL_W'($urandom_range(0, 131071)));
      endcase
      k = 0;
      while (k < ITEMS_PER_PHASE) begin
        if (ph == PHASES && k >= QUIET_FROM) quiet = 1'b1;
        sender_gap();
        rq = rand_req();
        send_req(rq);
        if (rq.req != REQ_SPARE_A && rq.req != REQ_SPARE_B) k++;
      end
      drain_block();
    end

    $display("covered %0d writes, %0d layer clears, %0d full clears, %0d spare codes",
             req_count[REQ_WRITE], req_count[REQ_CLR_LAYER], req_count[REQ_CLR_ALL],
             req_count[REQ_SPARE_A] + req_count[REQ_SPARE_B]);
    $display("%0d/%0d/%0d plain/below/safe resolves; %0d beats checked, %0d settings",
             req_count[REQ_RESOLVE], req_count[REQ_BELOW], req_count[REQ_SAFE],
             sb.beats_seen, PHASES + 1);
    if (sb.errors == 0 && sb.pending_res.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
